[hdl/assert_macros.svh]
// Assertion shorthands shared by the RTL; clk and rst_n are taken from the
// enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/sbsp_pkg.sv]
`default_nettype none

package sbsp_pkg;

  localparam int COUNT_W = 16;
  localparam int TALLY_N = 9;
  localparam int ATOM_N  = 4;

  localparam logic [15:0] TALLY_CODES [TALLY_N] = '{
    16'h001d, 16'h0010, 16'h0011, 16'h0015, 16'h0016,
    16'h0017, 16'h0018, 16'h0019, 16'h001e
  };

  // atom total slots
  localparam int ATOM_LOCAL = 0;
  localparam int ATOM_FORM  = 1;
  localparam int ATOM_INT   = 2;
  localparam int ATOM_FLOAT = 3;

  // record kinds
  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_TALLY = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  // final status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SIZE      = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_OVERRUN   = 2'd3;

  typedef logic [COUNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] opcode;
    logic        has_reference;
    logic [15:0] reference_index;
    logic [15:0] length_or_count;
    logic [15:0] local_refs;
    logic [15:0] form_refs;
    logic [15:0] int_literals;
    logic [15:0] float_literals;
    logic [1:0]  status;
    logic        last_result;
  } rec_t;

  // per-beat events from the parser to the output stage
  typedef struct packed {
    logic       rec_vld;
    logic       fin;
    logic [1:0] status;
    rec_t       rec;
  } pev_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

  function automatic logic [15:0] clamp16(input cnt_t c);
    return (32'(c) > 32'h0000_ffff) ? 16'hffff : 16'(c);
  endfunction

endpackage

`default_nettype wire

[hdl/script_bytecode_stream_parser.sv]
// Script bytecode stream parser. Takes one bytecode byte per input beat
// (in_tlast on the last byte of a stream) and decodes 16-bit little-endian
// opcode and length words, with opcode 0x1c wrapping a reference index ahead
// of the real opcode and length. Every finished instruction leaves as an
// instruction record; the last byte of a stream is followed by nine opcode
// tally records and one final record with saturating atom totals and a status
// (ok, size mismatch against expected_size when enabled, truncated header,
// payload overrun), marked by out_tlast. Rate: one byte per clock while the
// output keeps up. The last byte of a stream adds the tally and final
// records, sent by a sequencer in the output stage, during which
// in_tready stays low; a stalled output holds one record in the output
// register and one in the skid stage before input is held back. Records are
// registered in the output register, by way of the skid stage while the
// output stalls. Configure only while no stream is in flight.
`default_nettype none

module script_bytecode_stream_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // byte input
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tlast,   // final_byte
  // record output
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [15:0] start_offset, [31:16] opcode, [32] has_reference,
  // [48:33] reference_index, [64:49] length_or_count, [80:65] local_refs,
  // [96:81] form_refs, [112:97] int_literals, [128:113] float_literals,
  // [130:129] status, [135:131] zero
  output logic [135:0]      out_tdata,
  output logic [1:0]        out_tuser,  // [1:0] record_kind
  output logic              out_tlast,  // last_result
  // configuration
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import sbsp_pkg::*;

  // register index as seen at paddr[2]
  localparam logic REG_EXPECTED = 1'b0;
  localparam logic REG_CHECK    = 1'b1;

  localparam logic [3:0] BURST_LAST = 4'(TALLY_N);

  `include "assert_macros.svh"

  // configuration registers
  logic [15:0] expected_r;
  logic        chk_en_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      chk_en_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_EXPECTED: expected_r <= cfg_pwdata[15:0];
        REG_CHECK:    chk_en_r   <= cfg_pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_EXPECTED: cfg_prdata = {16'd0, expected_r};
      REG_CHECK:    cfg_prdata = {31'd0, chk_en_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // output stage: result register, skid register, end-of-stream sequencer
  rec_t       out_r, skid_r, burst_rec;
  logic       out_vld_r, skid_vld_r;
  logic       burst_r;
  logic [3:0] idx_r;
  logic [1:0] status_r;
  logic       out_free;
  logic       acc;
  logic       clr_counts;

  pev_t                     ev;
  logic [TALLY_N-1:0][15:0] tally_q;
  logic [ATOM_N-1:0][15:0]  atom_q;

  // hold input while the skid is full or the end-of-stream burst runs
  assign in_tready = !skid_vld_r && !burst_r;
  assign acc       = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  // the final record leaves the sequencer: clear totals and tallies
  assign clr_counts = out_free && !skid_vld_r && burst_r && idx_r == BURST_LAST;

  sbsp_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .acc               (acc),
    .data_byte         (in_tdata),
    .final_byte        (in_tlast),
    .expected_size     (expected_r),
    .size_check_enable (chk_en_r),
    .clr_counts        (clr_counts),
    .ev                (ev),
    .tally_q           (tally_q),
    .atom_q            (atom_q)
  );

  always_comb begin
    burst_rec = '0;
    if (idx_r == BURST_LAST) begin
      burst_rec.kind           = KIND_FINAL;
      burst_rec.local_refs     = atom_q[ATOM_LOCAL];
      burst_rec.form_refs      = atom_q[ATOM_FORM];
      burst_rec.int_literals   = atom_q[ATOM_INT];
      burst_rec.float_literals = atom_q[ATOM_FLOAT];
      burst_rec.status         = status_r;
      burst_rec.last_result    = 1'b1;
    end else begin
      burst_rec.kind            = KIND_TALLY;
      burst_rec.opcode          = TALLY_CODES[idx_r];
      burst_rec.length_or_count = tally_q[idx_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (ev.rec_vld) begin
        out_r <= ev.rec;
      end else if (burst_r) begin
        out_r <= burst_rec;
      end
    end else if (ev.rec_vld) begin
      skid_r <= ev.rec;
    end
    if (ev.fin) begin
      status_r <= ev.status;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
      burst_r    <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (out_free) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else if (ev.rec_vld) begin
          out_vld_r <= 1'b1;
        end else if (burst_r) begin
          out_vld_r <= 1'b1;
          if (idx_r == BURST_LAST) begin
            burst_r <= 1'b0;
          end
          idx_r <= idx_r + 4'd1;
        end else begin
          out_vld_r <= 1'b0;
        end
      end else if (ev.rec_vld) begin
        skid_vld_r <= 1'b1;
      end
      // start the tally burst behind this byte's instruction record
      if (ev.fin) begin
        burst_r <= 1'b1;
        idx_r   <= '0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last_result;
  assign out_tdata  = {5'd0, out_r.status, out_r.float_literals, out_r.int_literals,
                       out_r.form_refs, out_r.local_refs, out_r.length_or_count,
                       out_r.reference_index, out_r.has_reference, out_r.opcode,
                       out_r.start_offset};

  `ASSERT_ALWAYS(a_skid_behind_out, !skid_vld_r || out_vld_r,
                 "skid holds a beat while the output register is empty")
  `ASSERT_ALWAYS(a_idx_range, !burst_r || idx_r <= BURST_LAST,
                 "burst index past the final record")
  `ASSERT_NEXT(a_fin_starts_burst, ev.fin, burst_r && idx_r == 4'd0,
               "end of stream did not start the tally burst")
  `ASSERT_ALWAYS(a_last_is_final, !(out_vld_r && out_r.last_result) ||
                 out_r.kind == KIND_FINAL,
                 "last beat carries a non-final record")

endmodule

`default_nettype wire

[hdl/sbsp_parser.sv]
`default_nettype none

module sbsp_parser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            acc,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            final_byte,
  input  wire logic [15:0]                     expected_size,
  input  wire logic                            size_check_enable,
  input  wire logic                            clr_counts,
  output sbsp_pkg::pev_t                       ev,
  output logic [sbsp_pkg::TALLY_N-1:0][15:0]   tally_q,
  output logic [sbsp_pkg::ATOM_N-1:0][15:0]    atom_q
);
  import sbsp_pkg::*;

  localparam logic [2:0] PH_OP_LO   = 3'd0;
  localparam logic [2:0] PH_OP_HI   = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [15:0] WRAP_OPCODE = 16'h001c;

  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_L = 8'h6c;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_Z = 8'h7a;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] start_r, start_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] op_r, op_nxt;
  logic [15:0] ref_r, ref_nxt;
  logic        rflag_r, rflag_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic [3:0]  skip_r, skip_nxt;
  cnt_t        atom_r  [ATOM_N];
  cnt_t        atom_nxt[ATOM_N];
  cnt_t        tally_r  [TALLY_N];
  cnt_t        tally_nxt[TALLY_N];

  logic [15:0]       word;
  logic              finish;
  logic [ATOM_N-1:0] atom_inc;
  logic [15:0]       atom_size;
  logic [1:0]        atom_kind;
  logic              atom_hit;
  logic [1:0]        status;

  assign word = {data_byte, lo_r};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    lo_nxt    = lo_r;
    op_nxt    = op_r;
    ref_nxt   = ref_r;
    rflag_nxt = rflag_r;
    rem_nxt   = rem_r;
    tot_nxt   = tot_r;
    skip_nxt  = skip_r;
    finish    = 1'b0;
    atom_inc  = '0;
    atom_hit  = 1'b0;
    atom_kind = 2'd0;
    atom_size = 16'd0;
    status    = ST_OK;

    ev                     = '0;
    ev.rec.kind            = KIND_INSTR;
    ev.rec.start_offset    = start_r;
    ev.rec.opcode          = op_r;
    ev.rec.has_reference   = rflag_r;
    ev.rec.reference_index = rflag_r ? ref_r : 16'd0;
    ev.rec.length_or_count = (phase_r == PH_LEN_HI) ? word : tot_r;

    // classify a payload byte as an atom marker
    case (data_byte) inside
      CH_S, CH_L, CH_F: begin
        atom_hit = 1'b1; atom_kind = 2'(ATOM_LOCAL); atom_size = 16'd3;
      end
      CH_R, CH_G: begin
        atom_hit = 1'b1; atom_kind = 2'(ATOM_FORM); atom_size = 16'd3;
      end
      CH_N: begin
        atom_hit = 1'b1; atom_kind = 2'(ATOM_INT); atom_size = 16'd5;
      end
      CH_Z: begin
        atom_hit = 1'b1; atom_kind = 2'(ATOM_FLOAT); atom_size = 16'd9;
      end
      default: begin
        atom_hit = 1'b0;
      end
    endcase

    if (acc) begin
      unique case (phase_r)
        PH_OP_HI: begin
          op_nxt    = word;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          lo_nxt    = data_byte;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (!rflag_r && op_r == WRAP_OPCODE) begin
            rflag_nxt = 1'b1;
            ref_nxt   = word;
            phase_nxt = PH_OP_LO;
          end else begin
            tot_nxt  = word;
            rem_nxt  = word;
            skip_nxt = 4'd0;
            if (word == 16'd0) begin
              finish = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (skip_r != 4'd0) begin
            skip_nxt = skip_r - 4'd1;
          end else if (atom_hit && rem_r >= atom_size) begin
            atom_inc[atom_kind] = 1'b1;
            skip_nxt            = 4'(atom_size - 16'd1);
          end
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            finish = 1'b1;
          end
        end
        default: begin
          if (!rflag_r) begin
            start_nxt = pos_r;
          end
          lo_nxt    = data_byte;
          phase_nxt = PH_OP_HI;
        end
      endcase

      if (finish) begin
        ev.rec_vld = 1'b1;
        if (rflag_r) begin
          atom_inc[ATOM_FORM] = 1'b1;
        end
        rflag_nxt = 1'b0;
        ref_nxt   = 16'd0;
        phase_nxt = PH_OP_LO;
      end
    end

    for (int i = 0; i < TALLY_N; i++) begin
      tally_nxt[i] = (finish && op_r == TALLY_CODES[i]) ? sat_inc(tally_r[i]) : tally_r[i];
    end
    for (int i = 0; i < ATOM_N; i++) begin
      atom_nxt[i] = atom_inc[i] ? sat_inc(atom_r[i]) : atom_r[i];
    end

    if (acc && final_byte) begin
      if (phase_nxt == PH_PAYLOAD) begin
        status = ST_OVERRUN;
      end else if (phase_nxt != PH_OP_LO || rflag_nxt) begin
        status = ST_TRUNCATED;
      end else if (size_check_enable &&
                   ({1'b0, pos_r} + 17'd1) != {1'b0, expected_size}) begin
        status = ST_SIZE;
      end
      ev.fin    = 1'b1;
      ev.status = status;
      // drop stream state; totals and tallies clear once the burst has left
      phase_nxt = PH_OP_LO;
      pos_nxt   = 16'd0;
      start_nxt = 16'd0;
      lo_nxt    = 8'd0;
      op_nxt    = 16'd0;
      ref_nxt   = 16'd0;
      rflag_nxt = 1'b0;
      rem_nxt   = 16'd0;
      tot_nxt   = 16'd0;
      skip_nxt  = 4'd0;
    end else if (acc && pos_r != 16'hffff) begin
      pos_nxt = pos_r + 16'd1;
    end

    if (clr_counts) begin
      for (int i = 0; i < TALLY_N; i++) begin
        tally_nxt[i] = '0;
      end
      for (int i = 0; i < ATOM_N; i++) begin
        atom_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OP_LO;
      pos_r   <= '0;
      start_r <= '0;
      lo_r    <= '0;
      op_r    <= '0;
      ref_r   <= '0;
      rflag_r <= 1'b0;
      rem_r   <= '0;
      tot_r   <= '0;
      skip_r  <= '0;
      for (int i = 0; i < TALLY_N; i++) begin
        tally_r[i] <= '0;
      end
      for (int i = 0; i < ATOM_N; i++) begin
        atom_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      lo_r    <= lo_nxt;
      op_r    <= op_nxt;
      ref_r   <= ref_nxt;
      rflag_r <= rflag_nxt;
      rem_r   <= rem_nxt;
      tot_r   <= tot_nxt;
      skip_r  <= skip_nxt;
      for (int i = 0; i < TALLY_N; i++) begin
        tally_r[i] <= tally_nxt[i];
      end
      for (int i = 0; i < ATOM_N; i++) begin
        atom_r[i] <= atom_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TALLY_N; i++) begin
      tally_q[i] = clamp16(tally_r[i]);
    end
    for (int i = 0; i < ATOM_N; i++) begin
      atom_q[i] = clamp16(atom_r[i]);
    end
  end

endmodule

`default_nettype wire
